[src/tcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, constants and the CORDIC arctangent table for the tilt filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int SENSOR_COUNT_DEF = 3;
    localparam int CORDIC_STEPS_DEF = 16;

    // CORDIC datapath width (inputs scaled by 256 plus gain headroom)
    localparam int CW = 28;
    // Blend multiplier operand widths
    localparam int MA_W = 34;
    localparam int MB_W = 18;
    localparam int MP_W = MA_W + MB_W;

    localparam logic signed [15:0] ANGLE_LIMIT = 16'sd23040;
    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam logic [16:0] WEIGHT_RESET = 17'd64225;
    localparam logic [15:0] GAIN_RESET = 16'd32787;

    // Configuration register indexes
    localparam logic [3:0] CFG_BLEND_WEIGHT = 4'd0;
    localparam logic [3:0] CFG_GYRO_GAIN = 4'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_Y,
        S_SQ_Z,
        S_START1,
        S_WAIT1,
        S_START2,
        S_WAIT2,
        S_START3,
        S_WAIT3,
        S_OUT
    } tcf_state_t;

    // Unit start strobes from the sequencer
    typedef struct packed {
        logic cordic_start;
        logic sqrt_start;
        logic blend_start;
    } tcf_ctrl_t;

    // atan(2^-i) in Q16 degrees
    function automatic logic signed [CW-1:0] atan_q16(input logic [4:0] i);
        logic signed [CW-1:0] r;
        case (i)
            5'd0: r = 28'sd2949120;
            5'd1: r = 28'sd1740967;
            5'd2: r = 28'sd919879;
            5'd3: r = 28'sd466945;
            5'd4: r = 28'sd234378;
            5'd5: r = 28'sd117304;
            5'd6: r = 28'sd58666;
            5'd7: r = 28'sd29335;
            5'd8: r = 28'sd14668;
            5'd9: r = 28'sd7334;
            5'd10: r = 28'sd3667;
            5'd11: r = 28'sd1833;
            5'd12: r = 28'sd917;
            5'd13: r = 28'sd458;
            5'd14: r = 28'sd229;
            5'd15: r = 28'sd115;
            5'd16: r = 28'sd57;
            5'd17: r = 28'sd29;
            5'd18: r = 28'sd14;
            5'd19: r = 28'sd7;
            5'd20: r = 28'sd4;
            5'd21: r = 28'sd2;
            5'd22: r = 28'sd1;
            default: r = 28'sd0;
        endcase
        return r;
    endfunction

endpackage

[src/tilt_complementary_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_complementary_filter
// Roll/pitch complementary filter for several IMUs on shared CORDIC, root
// and multiply units under one sequencer.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+----------------------------------------
//  in       | in_valid / in_stall  | sensor_index, accel_x/y/z, gyro_x/y, ts
//  out      | out_valid / out_stall| sensor_tag, roll_out, pitch_out
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A sample passes the two squaring states, the roll CORDIC beside the square
//  root, the pitch CORDIC beside the roll blend, then the pitch blend, before the
//  output register; the next sample is taken once the sequencer is back in idle.
//  in_stall is high from acceptance until the result enters the output register.
//  A sample with an out-of-range index is taken and dropped.
//  Reset clears per-sensor angles and timestamps and loads default registers.
// ----------------------------------------------------------------------------
module tilt_complementary_filter
    import tcf_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         sensor_index,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic [31:0]        timestamp_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         sensor_tag,
    output logic signed [15:0] roll_out,
    output logic signed [15:0] pitch_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    tcf_state_t state_reg, state_next;
    tcf_ctrl_t  ctrl;

    logic [16:0] weight_reg;
    logic [15:0] gain_reg;

    logic signed [15:0] roll_mem [SENSOR_COUNT];
    logic signed [15:0] pitch_mem [SENSOR_COUNT];
    logic [31:0]        time_mem [SENSOR_COUNT];

    logic [1:0]         tag_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic [31:0]        ts_reg;
    logic [31:0]        sq_reg;
    logic [15:0]        dt_reg;
    logic signed [15:0] roll_res_reg;

    logic               out_valid_reg;
    logic [1:0]         out_tag_reg;
    logic signed [15:0] out_roll_reg, out_pitch_reg;

    logic [3:0]         idx_wide;
    logic               idx_ok, in_xfer, out_free;
    logic signed [15:0] sq_op;
    logic signed [31:0] sq_term;
    logic [31:0]        dt_full;
    logic signed [CW-1:0] cy, cx, c_angle;
    logic               c_busy, r_busy, b_busy;
    logic [23:0]        mag;
    logic signed [15:0] b_prev, b_rate, b_res;

    assign idx_wide = {2'b00, sensor_index};
    assign idx_ok = idx_wide < 4'(SENSOR_COUNT);
    assign in_xfer = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Shared squarer: ay^2 then az^2
    assign sq_op = (state_reg == S_SQ_Y) ? ay_reg : az_reg;
    assign sq_term = sq_op * sq_op;
    assign dt_full = ts_reg - time_mem[idx_reg];

    // Operand select for the shared CORDIC
    always_comb
    begin
        if (state_reg == S_START1)
        begin
            cy = CW'(ay_reg) <<< 8;
            cx = CW'(az_reg) <<< 8;
        end
        else
        begin
            cy = -(CW'(ax_reg) <<< 8);
            cx = CW'({4'b0000, mag});
        end
    end

    assign b_prev = (state_reg == S_START2) ? roll_mem[idx_reg] : pitch_mem[idx_reg];
    assign b_rate = (state_reg == S_START2) ? gx_reg : gy_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && idx_ok)
                    state_next = S_SQ_Y;
            S_SQ_Y:   state_next = S_SQ_Z;
            S_SQ_Z:   state_next = S_START1;
            S_START1: state_next = S_WAIT1;
            S_WAIT1:
                if (!c_busy && !r_busy)
                    state_next = S_START2;
            S_START2: state_next = S_WAIT2;
            S_WAIT2:
                if (!c_busy && !b_busy)
                    state_next = S_START3;
            S_START3: state_next = S_WAIT3;
            S_WAIT3:
                if (!b_busy)
                    state_next = S_OUT;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Unit strobes
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            S_START1:
            begin
                ctrl.cordic_start = 1'b1;
                ctrl.sqrt_start = 1'b1;
            end
            S_START2:
            begin
                ctrl.cordic_start = 1'b1;
                ctrl.blend_start = 1'b1;
            end
            S_START3: ctrl.blend_start = 1'b1;
            default:  ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_BLEND_WEIGHT)
                weight_reg <= cfg_data;
            else if (cfg_index == CFG_GYRO_GAIN)
                gain_reg <= cfg_data[15:0];
        end
    end

    // Capture sample, squares, dt and roll result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tag_reg <= sensor_index;
            idx_reg <= idx_wide[IDX_W-1:0];
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gx_reg <= gyro_x;
            gy_reg <= gyro_y;
            ts_reg <= timestamp_ms;
        end
        if (state_reg == S_SQ_Y)
            sq_reg <= 32'(sq_term);
        if (state_reg == S_SQ_Z)
        begin
            sq_reg <= sq_reg + 32'(sq_term);
            dt_reg <= (dt_full > 32'd65535) ? 16'hFFFF : dt_full[15:0];
        end
        if (state_reg == S_WAIT2 && state_next == S_START3)
            roll_res_reg <= b_res;
    end

    // Per-sensor state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                roll_mem[i] <= '0;
                pitch_mem[i] <= '0;
                time_mem[i] <= '0;
            end
        end
        else if (state_reg == S_OUT && out_free)
        begin
            roll_mem[idx_reg] <= roll_res_reg;
            pitch_mem[idx_reg] <= b_res;
            time_mem[idx_reg] <= ts_reg;
        end
    end

    // Output register: hold until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            out_tag_reg <= tag_reg;
            out_roll_reg <= roll_res_reg;
            out_pitch_reg <= b_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign sensor_tag = out_tag_reg;
    assign roll_out = out_roll_reg;
    assign pitch_out = out_pitch_reg;

    tcf_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.cordic_start),
        .y_in  (cy),
        .x_in  (cx),
        .busy  (c_busy),
        .angle (c_angle)
    );

    tcf_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.sqrt_start),
        .value ({sq_reg, 16'h0000}),
        .busy  (r_busy),
        .root  (mag)
    );

    tcf_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ctrl.blend_start),
        .prev   (b_prev),
        .rate   (b_rate),
        .dt     (dt_reg),
        .acc    (c_angle),
        .weight (weight_reg),
        .gain   (gain_reg),
        .busy   (b_busy),
        .result (b_res)
    );

    // Units are quiet whenever the sequencer is idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!c_busy && !r_busy && !b_busy))
        else $error("arithmetic unit busy while idle");

    // Loading the output register always raises out_valid
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> out_valid)
        else $error("result lost at output register");

    // Blend is never started while the blend or the square root still runs
    a_blend_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.blend_start |-> (!b_busy && !r_busy))
        else $error("blend started over a busy unit");

endmodule

[src/tcf_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_cordic
// Vectoring CORDIC, one micro-rotation per cycle; gives atan2(y, x) in Q16 deg.
// ----------------------------------------------------------------------------
module tcf_cordic
    import tcf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] x_in,
    output logic                 busy,
    output logic signed [CW-1:0] angle
);

    localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     iter_reg, iter_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [CW-1:0] dx, dy, at;

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = atan_q16(5'(iter_reg));

    // Pre-rotate into the right half plane, then rotate toward y = 0
    always_comb
    begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (start)
        begin
            iter_next = '0;
            x_next = x_in;
            y_next = y_in;
            z_next = '0;
            busy_next = !(x_in == '0 && y_in == '0);
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_next = y_in;
                    y_next = -x_in;
                    z_next = 28'sd5898240;
                end
                else
                begin
                    x_next = -y_in;
                    y_next = x_in;
                    z_next = -28'sd5898240;
                end
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign busy = busy_reg;
    assign angle = z_reg;

endmodule

[src/tcf_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_isqrt
// Restoring integer square root of a 48-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module tcf_isqrt
    import tcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] value,
    output logic        busy,
    output logic [23:0] root
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [47:0] v_reg;
    logic [25:0] rem_reg;
    logic [23:0] root_reg;
    logic [25:0] rem_sh, trial;

    assign rem_sh = {rem_reg[23:0], v_reg[47:46]};
    assign trial = {root_reg, 2'b01};

    // Control: run 24 digit steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 5'd23)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: bring down two bits, try to subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= value;
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[45:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg <= rem_sh - trial;
                root_reg <= {root_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                root_reg <= {root_reg[22:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

[src/tcf_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_blend
// Complementary blend of one axis on a single shared multiplier.
// ----------------------------------------------------------------------------
module tcf_blend
    import tcf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [15:0]   prev,
    input  logic signed [15:0]   rate,
    input  logic [15:0]          dt,
    input  logic signed [CW-1:0] acc,
    input  logic [16:0]          weight,
    input  logic [15:0]          gain,
    output logic                 busy,
    output logic signed [15:0]   result
);

    logic                   busy_reg;
    logic [3:0]             ph_reg;
    logic signed [15:0]     prev_reg;
    logic signed [CW-1:0]   acc_reg;
    logic [15:0]            dt_reg;
    logic [16:0]            w_reg;
    logic signed [MA_W-1:0] a_reg;
    logic signed [MB_W-1:0] b_reg;
    logic signed [MP_W-1:0] p_reg, psum_reg;
    logic signed [15:0]     res_reg;
    logic signed [MP_W-1:0] inc_rnd;
    logic signed [MA_W-1:0] pred;
    logic signed [MP_W:0]   total;
    logic signed [MP_W-25:0] scaled;
    logic [16:0]            w_eff;

    assign w_eff = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    assign inc_rnd = (p_reg + MP_W'(32768)) >>> 16;
    assign pred = (MA_W'(prev_reg) <<< 9) + inc_rnd[MA_W-1:0];
    assign total = (MP_W+1)'(psum_reg) + (MP_W+1)'(p_reg) + (MP_W+1)'(33'sd16777216);
    assign scaled = total[MP_W:25];

    // Sequence: rate*gain, *dt, w*pred, (1-w)*acc, round and clamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            ph_reg <= '0;
        end
        else if (busy_reg)
        begin
            ph_reg <= ph_reg + 1'b1;
            if (ph_reg == 4'd7)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= a_reg * b_reg;
        if (start)
        begin
            prev_reg <= prev;
            acc_reg <= acc;
            dt_reg <= dt;
            w_reg <= w_eff;
            a_reg <= MA_W'(rate);
            b_reg <= MB_W'({2'b00, gain});
        end
        else if (busy_reg)
        begin
            case (ph_reg)
                4'd1:
                begin
                    a_reg <= p_reg[MA_W-1:0];
                    b_reg <= MB_W'({2'b00, dt_reg});
                end
                4'd3:
                begin
                    a_reg <= pred;
                    b_reg <= MB_W'({1'b0, w_reg});
                end
                4'd5:
                begin
                    psum_reg <= p_reg;
                    a_reg <= MA_W'(acc_reg);
                    b_reg <= MB_W'({1'b0, WEIGHT_ONE - w_reg});
                end
                4'd7:
                begin
                    if (scaled > MP_W'(ANGLE_LIMIT))
                        res_reg <= ANGLE_LIMIT;
                    else if (scaled < -MP_W'(ANGLE_LIMIT))
                        res_reg <= -ANGLE_LIMIT;
                    else
                        res_reg <= scaled[15:0];
                end
                default:
                begin
                    a_reg <= a_reg;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign result = res_reg;

endmodule
